FILE: rtl/bitmap_page_frame_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// bitmap page frame allocator assertion macros
// concurrent checks in simulation, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpfa: assertion failed");
`define BPFA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bpfa: forbidden condition seen");
`else
`define BPFA_ASSERT(lbl, clk, rst_n, prop)
`define BPFA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// constants, command codes and state type of the page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int ADDR_W        = 48;
    localparam int MAX_PAGES     = 4096;
    localparam int CNT_W         = $clog2(MAX_PAGES + 1);
    localparam int IDX_W         = $clog2(MAX_PAGES);
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
    localparam int BITS_PER_BYTE = 8;
    localparam int BYTE_SHIFT    = $clog2(BITS_PER_BYTE);
    localparam int WORD_BITS     = 32;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_END   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_INIT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_BASE,
        ST_INIT_SIZE,
        ST_INIT_MAP,
        ST_ALLOC,
        ST_FREE_CHK,
        ST_FREE_WR
    } t_state;

endpackage

FILE: rtl/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bitmap_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// next-fit page frame allocator over a used/free bitmap held in a ram
//
//   channel   direction  handshake                     payload
//   command   in         start & !busy                 i_command, i_address
//   result    out        o_done (one cycle, no stall)  o_page_address, o_found,
//                                                      o_free_count
//   config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// count answers from idle; init steps through base, size and map states;
// free skips the row write when the address is out of range; allocate reads
// 1 to rows+1 bitmap rows, one row per cycle through the ram read port; with
// no free page it answers from idle; reset and init clear row valid flops, an
// invalid row reads as the init pattern; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_core_assert.svh"

module bitmap_page_frame_allocator_core #(
    parameter int P_WORD_BITS = bpfa_pkg::WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [bpfa_pkg::CMD_W-1:0]        i_command,
    input  logic [bpfa_pkg::ADDR_W-1:0]       i_address,
    output logic                              busy,
    output logic                              o_done,
    output logic [bpfa_pkg::ADDR_W-1:0]       o_page_address,
    output logic                              o_found,
    output logic [bpfa_pkg::CNT_W-1:0]        o_free_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]       i_cfg_data
);

    localparam int ADDR_W = bpfa_pkg::ADDR_W;
    localparam int CNT_W  = bpfa_pkg::CNT_W;
    localparam int IDX_W  = bpfa_pkg::IDX_W;
    localparam int PSH    = bpfa_pkg::PAGE_SHIFT;
    localparam int W      = P_WORD_BITS;
    localparam int LW     = $clog2(W);
    localparam int ROWS   = bpfa_pkg::MAX_PAGES / W;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int Q_W    = ADDR_W - PSH;
    localparam int MP_W   = CNT_W + PSH + 1;

    bpfa_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0]  r_memory_end, r_reserved_end;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_map_pages, n_map_pages;
    logic [ADDR_W:0]    r_limit, n_limit;
    logic [ROW_W:0]     r_words, n_words;
    logic [CNT_W-1:0]   r_hint, n_hint;
    logic [CNT_W-1:0]   r_free, n_free;
    logic [ROWS-1:0]    r_row_valid, n_row_valid;
    logic               r_rd_pend, n_rd_pend;
    logic               r_done, n_done;

    logic [ADDR_W-1:0]  r_cmd_addr, n_cmd_addr;
    logic [ROW_W-1:0]   r_scan_row, n_scan_row;
    logic [ROW_W-1:0]   r_rd_row, n_rd_row;
    logic               r_rd_first, n_rd_first;
    logic               r_first_issue, n_first_issue;
    logic [LW-1:0]      r_first_off, n_first_off;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic [ADDR_W-1:0]  r_out_page, n_out_page;
    logic               r_out_found, n_out_found;
    logic [CNT_W-1:0]   r_out_count, n_out_count;

    logic               ram_we, ram_re;
    logic [ROW_W-1:0]   ram_waddr, ram_raddr;
    logic [W-1:0]       ram_wdata, ram_q;

    logic [W-1:0]       pattern, rd_word, scan_word;
    logic [IDX_W-1:0]   pat_idx;
    logic               scan_hit;
    logic [LW-1:0]      hit_pos;
    logic [IDX_W-1:0]   hit_idx;
    logic [ADDR_W-1:0]  alloc_addr;
    logic               free_in_range;
    logic [ADDR_W-1:0]  free_diff;
    logic [IDX_W-1:0]   free_idx;
    logic [ADDR_W:0]    base_sum;
    logic [ADDR_W-1:0]  size_diff;
    logic [Q_W-1:0]     size_q;
    logic [CNT_W-1:0]   size_pages;
    logic [CNT_W:0]     map_bytes;
    logic [MP_W-1:0]    map_sum;
    logic [CNT_W-1:0]   map_pages;
    logic [CNT_W:0]     words_sum;
    logic               hint_ok;
    logic [ROW_W:0]     scan_next;
    bpfa_pkg::t_cmd     cmd;

    bpfa_ram #(
        .P_WIDTH (W),
        .P_DEPTH (ROWS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign busy           = (r_state != bpfa_pkg::ST_IDLE);
    assign o_done         = r_done;
    assign o_page_address = r_out_page;
    assign o_found        = r_out_found;
    assign o_free_count   = r_out_count;
    assign o_cfg_ready    = 1'b1;
    assign cmd            = bpfa_pkg::t_cmd'(i_command);

    // row data, never written rows read as the init pattern
    always_comb begin
        pat_idx = '0;
        for (int b = 0; b < W; b++) begin
            pat_idx    = {r_rd_row, LW'(b)};
            pattern[b] = !((CNT_W'(pat_idx) >= r_map_pages) && (CNT_W'(pat_idx) < r_total));
        end
        rd_word = r_row_valid[r_rd_row] ? ram_q : pattern;
    end

    // lowest free bit, bits below the hint masked in the first row
    always_comb begin
        scan_hit = 1'b0;
        hit_pos  = '0;
        for (int b = 0; b < W; b++) begin
            scan_word[b] = rd_word[b] | (r_rd_first && (LW'(b) < r_first_off));
        end
        for (int b = W - 1; b >= 0; b--) begin
            if (!scan_word[b]) begin
                scan_hit = 1'b1;
                hit_pos  = LW'(b);
            end
        end
        hit_idx    = {r_rd_row, hit_pos};
        alloc_addr = r_base + (ADDR_W'(hit_idx) << PSH);
    end

    always_comb begin
        free_in_range = (r_cmd_addr >= r_base) && ({1'b0, r_cmd_addr} < r_limit);
        free_diff     = r_cmd_addr - r_base;
        free_idx      = free_diff[PSH +: IDX_W];

        base_sum   = {1'b0, r_reserved_end} + (ADDR_W + 1)'(bpfa_pkg::PAGE_BYTES - 1);
        size_diff  = r_memory_end - r_base;
        size_q     = size_diff[ADDR_W-1:PSH];
        if (r_memory_end <= r_base) begin
            size_pages = '0;
        end else if (size_q > Q_W'(bpfa_pkg::MAX_PAGES)) begin
            size_pages = CNT_W'(bpfa_pkg::MAX_PAGES);
        end else begin
            size_pages = CNT_W'(size_q);
        end

        map_bytes = ({1'b0, r_total} + (CNT_W + 1)'(bpfa_pkg::BITS_PER_BYTE - 1))
                    >> bpfa_pkg::BYTE_SHIFT;
        map_sum   = MP_W'(map_bytes) + MP_W'(bpfa_pkg::PAGE_BYTES - 1);
        map_pages = CNT_W'(map_sum >> PSH);
        words_sum = {1'b0, r_total} + (CNT_W + 1)'(W - 1);

        hint_ok   = (r_hint < r_total);
        scan_next = {1'b0, r_scan_row} + (ROW_W + 1)'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpfa_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (cmd)
                        bpfa_pkg::CMD_ALLOC: begin
                            n_state = (r_free == '0) ? bpfa_pkg::ST_IDLE : bpfa_pkg::ST_ALLOC;
                        end
                        bpfa_pkg::CMD_FREE:  n_state = bpfa_pkg::ST_FREE_CHK;
                        bpfa_pkg::CMD_COUNT: n_state = bpfa_pkg::ST_IDLE;
                        bpfa_pkg::CMD_INIT:  n_state = bpfa_pkg::ST_INIT_BASE;
                        default:             n_state = bpfa_pkg::ST_IDLE;
                    endcase
                end
            end
            bpfa_pkg::ST_INIT_BASE: n_state = bpfa_pkg::ST_INIT_SIZE;
            bpfa_pkg::ST_INIT_SIZE: n_state = bpfa_pkg::ST_INIT_MAP;
            bpfa_pkg::ST_INIT_MAP:  n_state = bpfa_pkg::ST_IDLE;
            bpfa_pkg::ST_ALLOC: begin
                if (r_rd_pend && scan_hit) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_FREE_CHK: begin
                n_state = free_in_range ? bpfa_pkg::ST_FREE_WR : bpfa_pkg::ST_IDLE;
            end
            bpfa_pkg::ST_FREE_WR: n_state = bpfa_pkg::ST_IDLE;
            default:              n_state = bpfa_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_base        = r_base;
        n_total       = r_total;
        n_map_pages   = r_map_pages;
        n_limit       = r_limit;
        n_words       = r_words;
        n_hint        = r_hint;
        n_free        = r_free;
        n_row_valid   = r_row_valid;
        n_rd_pend     = 1'b0;
        n_done        = 1'b0;
        n_cmd_addr    = r_cmd_addr;
        n_scan_row    = r_scan_row;
        n_rd_row      = r_rd_row;
        n_rd_first    = r_rd_first;
        n_first_issue = r_first_issue;
        n_first_off   = r_first_off;
        n_free_idx    = r_free_idx;
        n_out_page    = r_out_page;
        n_out_found   = r_out_found;
        n_out_count   = r_out_count;
        ram_we        = 1'b0;
        ram_waddr     = r_rd_row;
        ram_wdata     = rd_word;
        ram_re        = 1'b0;
        ram_raddr     = r_scan_row;

        unique case (r_state)
            bpfa_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd_addr    = i_address;
                    n_first_issue = 1'b1;
                    n_scan_row    = hint_ok ? r_hint[IDX_W-1:LW] : '0;
                    n_first_off   = hint_ok ? r_hint[LW-1:0] : '0;
                    n_out_page    = '0;
                    n_out_found   = 1'b0;
                    n_out_count   = '0;
                    if (cmd == bpfa_pkg::CMD_COUNT) begin
                        n_done      = 1'b1;
                        n_out_count = r_free;
                    end else if (cmd == bpfa_pkg::CMD_ALLOC && r_free == '0) begin
                        n_done = 1'b1;
                    end
                end
            end
            bpfa_pkg::ST_INIT_BASE: begin
                n_base = {base_sum[ADDR_W-1:PSH], PSH'(0)};
            end
            bpfa_pkg::ST_INIT_SIZE: begin
                n_total = size_pages;
            end
            bpfa_pkg::ST_INIT_MAP: begin
                n_map_pages = map_pages;
                n_limit     = {1'b0, r_base} + ((ADDR_W + 1)'(r_total) << PSH);
                n_words     = (ROW_W + 1)'(words_sum >> LW);
                n_free      = (r_total > map_pages) ? (r_total - map_pages) : '0;
                n_hint      = '0;
                n_row_valid = '0;
                n_done      = 1'b1;
            end
            bpfa_pkg::ST_ALLOC: begin
                ram_re        = 1'b1;
                ram_raddr     = r_scan_row;
                n_scan_row    = (scan_next == r_words) ? '0 : scan_next[ROW_W-1:0];
                n_rd_pend     = 1'b1;
                n_rd_row      = r_scan_row;
                n_rd_first    = r_first_issue;
                n_first_issue = 1'b0;
                if (r_rd_pend && scan_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_row;
                    for (int b = 0; b < W; b++) begin
                        ram_wdata[b] = rd_word[b] | (LW'(b) == hit_pos);
                    end
                    n_row_valid[r_rd_row] = 1'b1;
                    n_hint      = CNT_W'(hit_idx) + CNT_W'(1);
                    n_free      = r_free - CNT_W'(1);
                    n_rd_pend   = 1'b0;
                    n_done      = 1'b1;
                    n_out_page  = alloc_addr;
                    n_out_found = 1'b1;
                end
            end
            bpfa_pkg::ST_FREE_CHK: begin
                if (free_in_range) begin
                    ram_re     = 1'b1;
                    ram_raddr  = free_idx[IDX_W-1:LW];
                    n_rd_row   = free_idx[IDX_W-1:LW];
                    n_free_idx = free_idx;
                end else begin
                    n_done = 1'b1;
                end
            end
            bpfa_pkg::ST_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_rd_row;
                for (int b = 0; b < W; b++) begin
                    ram_wdata[b] = rd_word[b] & (LW'(b) != r_free_idx[LW-1:0]);
                end
                n_row_valid[r_rd_row] = 1'b1;
                if (rd_word[r_free_idx[LW-1:0]]) begin
                    n_free = r_free + CNT_W'(1);
                end
                if (CNT_W'(r_free_idx) < r_hint) begin
                    n_hint = CNT_W'(r_free_idx);
                end
                n_done = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= bpfa_pkg::ST_IDLE;
            r_memory_end   <= '0;
            r_reserved_end <= '0;
            r_base         <= '0;
            r_total        <= '0;
            r_map_pages    <= '0;
            r_limit        <= '0;
            r_words        <= '0;
            r_hint         <= '0;
            r_free         <= '0;
            r_row_valid    <= '0;
            r_rd_pend      <= 1'b0;
            r_done         <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_total     <= n_total;
            r_map_pages <= n_map_pages;
            r_limit     <= n_limit;
            r_words     <= n_words;
            r_hint      <= n_hint;
            r_free      <= n_free;
            r_row_valid <= n_row_valid;
            r_rd_pend   <= n_rd_pend;
            r_done      <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    bpfa_pkg::CFG_MEMORY_END:   r_memory_end   <= i_cfg_data;
                    bpfa_pkg::CFG_RESERVED_END: r_reserved_end <= i_cfg_data;
                    default:                    r_memory_end   <= r_memory_end;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd_addr    <= n_cmd_addr;
        r_scan_row    <= n_scan_row;
        r_rd_row      <= n_rd_row;
        r_rd_first    <= n_rd_first;
        r_first_issue <= n_first_issue;
        r_first_off   <= n_first_off;
        r_free_idx    <= n_free_idx;
        r_out_page    <= n_out_page;
        r_out_found   <= n_out_found;
        r_out_count   <= n_out_count;
    end

    // page total is updated in the init state before the one that sets free count and hint
    `BPFA_ASSERT(a_free_le_total, i_clk, i_rst_n,
        (r_state == bpfa_pkg::ST_INIT_MAP) || (r_free <= r_total))
    `BPFA_ASSERT(a_hint_le_total, i_clk, i_rst_n,
        (r_state == bpfa_pkg::ST_INIT_MAP) || (r_hint <= r_total))
    `BPFA_ASSERT(a_done_after_cmd, i_clk, i_rst_n, o_done |-> $past(start || busy))
    `BPFA_ASSERT_NEVER(a_scan_with_none_free, i_clk, i_rst_n,
        busy && r_state == bpfa_pkg::ST_ALLOC && r_free == '0)

endmodule

FILE: verif/bitmap_page_frame_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core_tb
// drives allocate, free, count and init commands through the start/busy port,
// reprograms the memory window between phases and checks every result against
// a cycle-free model of the next-fit bitmap allocator kept in this file
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core_tb;

    localparam int ADDR_W        = bpfa_pkg::ADDR_W;
    localparam int CNT_W         = bpfa_pkg::CNT_W;
    localparam int CMD_W         = bpfa_pkg::CMD_W;
    localparam int CFG_IDX_W     = bpfa_pkg::CFG_IDX_W;
    localparam int MAX_PAGES     = bpfa_pkg::MAX_PAGES;
    localparam int PAGE_BYTES    = bpfa_pkg::PAGE_BYTES;
    localparam int PAGE_SHIFT    = bpfa_pkg::PAGE_SHIFT;
    localparam int BITS_PER_BYTE = bpfa_pkg::BITS_PER_BYTE;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct packed {
        bpfa_pkg::t_cmd    op;
        logic [ADDR_W-1:0] addr;
        logic              drain;
    } t_cmd_item;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              found;
        logic [CNT_W-1:0]  free_count;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [CMD_W-1:0]     i_command = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic                 busy;
    logic                 o_done;
    logic [ADDR_W-1:0]    o_page_address;
    logic                 o_found;
    logic [CNT_W-1:0]     o_free_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_data = '0;

    t_cmd_item     cmd_backlog[$];
    t_frame_result page_results_due[$];
    int            idle_pct = 0;
    logic          cmd_taken = 1'b0;
    int            mismatches = 0;
    int            stall_cycles = 0;

    // allocator model state
    bit                frame_used[MAX_PAGES];
    int unsigned       next_hint = 0;
    logic [ADDR_W-1:0] frame_base = '0;
    int unsigned       frame_total = 0;
    logic [ADDR_W-1:0] cfg_mem_end = '0;
    logic [ADDR_W-1:0] cfg_res_end = '0;

    bitmap_page_frame_allocator_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .i_address      (i_address),
        .busy           (busy),
        .o_done         (o_done),
        .o_page_address (o_page_address),
        .o_found        (o_found),
        .o_free_count   (o_free_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_frame_result step_allocator(bpfa_pkg::t_cmd op,
                                                     logic [ADDR_W-1:0] addr);
        t_frame_result     r;
        int unsigned       h;
        int unsigned       idx;
        logic [63:0]       lim;
        logic [63:0]       rounded;
        logic [ADDR_W-1:0] span;
        int unsigned       map_pages;
        r = '0;
        case (op)
            bpfa_pkg::CMD_ALLOC: begin
                h = (next_hint < frame_total) ? next_hint : frame_total;
                // next fit from the hint, wrapping to page zero
                for (int k = 0; k < frame_total && !r.found; k++) begin
                    idx = (h + k) % frame_total;
                    if (!frame_used[idx]) begin
                        frame_used[idx] = 1'b1;
                        next_hint = idx + 1;
                        r.page_address = frame_base + (ADDR_W'(idx) << PAGE_SHIFT);
                        r.found = 1'b1;
                    end
                end
            end
            bpfa_pkg::CMD_FREE: begin
                lim = {16'b0, frame_base} + 64'(frame_total) * PAGE_BYTES;
                if (addr >= frame_base && {16'b0, addr} < lim) begin
                    idx = (addr - frame_base) >> PAGE_SHIFT;
                    frame_used[idx] = 1'b0;
                    if (idx < next_hint)
                        next_hint = idx;
                end
            end
            bpfa_pkg::CMD_COUNT: begin
                for (int k = 0; k < frame_total; k++)
                    if (!frame_used[k])
                        r.free_count++;
            end
            default: begin
                rounded = ({16'b0, cfg_res_end} + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);
                frame_base = rounded[ADDR_W-1:0];
                span = (cfg_mem_end > frame_base) ? (cfg_mem_end - frame_base) >> PAGE_SHIFT : '0;
                frame_total = (span > MAX_PAGES) ? MAX_PAGES : int'(span);
                // pages that hold the bitmap itself
                map_pages = ((frame_total + BITS_PER_BYTE - 1) / BITS_PER_BYTE
                             + PAGE_BYTES - 1) / PAGE_BYTES;
                for (int k = 0; k < MAX_PAGES; k++)
                    frame_used[k] = !(k < frame_total && k >= map_pages);
                next_hint = 0;
            end
        endcase
        return r;
    endfunction

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct
                    && (!cmd_backlog[0].drain || page_results_due.size() == 0)) begin
                start     <= 1'b1;
                i_command <= cmd_backlog[0].op;
                i_address <= cmd_backlog[0].addr;
                void'(cmd_backlog.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and model update
    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        cmd_taken <= start && !busy;
        if (i_rst_n) begin
            if (o_done) begin
                if (page_results_due.size() == 0) begin
                    $display("%0t: result with none due: page_address %h found %0d count %0d",
                             $realtime, o_page_address, o_found, o_free_count);
                    mismatches++;
                end else begin
                    want = page_results_due.pop_front();
                    if (o_page_address !== want.page_address) begin
                        $display("%0t: page_address expected %h actual %h",
                                 $realtime, want.page_address, o_page_address);
                        mismatches++;
                    end
                    if (o_found !== want.found) begin
                        $display("%0t: found expected %0d actual %0d",
                                 $realtime, want.found, o_found);
                        mismatches++;
                    end
                    if (o_free_count !== want.free_count) begin
                        $display("%0t: free_count expected %0d actual %0d",
                                 $realtime, want.free_count, o_free_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                page_results_due.push_back(step_allocator(bpfa_pkg::t_cmd'(i_command),
                                                          i_address));
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bpfa_pkg::CFG_MEMORY_END)
                    cfg_mem_end = i_cfg_data;
                else
                    cfg_res_end = i_cfg_data;
            end
            if (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic queue_cmd(bpfa_pkg::t_cmd op, logic [ADDR_W-1:0] a, logic d = 1'b0);
        t_cmd_item it;
        it.op    = op;
        it.addr  = a;
        it.drain = d;
        cmd_backlog.push_back(it);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || start || page_results_due.size() != 0);
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] res, logic [ADDR_W-1:0] mem,
                             int idle, int n, logic hold);
        logic [63:0]       rounded;
        logic [ADDR_W-1:0] base_g;
        logic [ADDR_W-1:0] pspan;
        int unsigned       span;
        int                roll;
        logic [ADDR_W-1:0] a;
        idle_pct = idle;
        cfg_write(bpfa_pkg::CFG_MEMORY_END, mem);
        cfg_write(bpfa_pkg::CFG_RESERVED_END, res);
        rounded = ({16'b0, res} + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);
        base_g = rounded[ADDR_W-1:0];
        pspan = (mem > base_g) ? (mem - base_g) >> PAGE_SHIFT : '0;
        span = (pspan > MAX_PAGES) ? MAX_PAGES : int'(pspan);
        queue_cmd(bpfa_pkg::CMD_INIT, rand_addr());
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            a = rand_addr();
            if (roll < 42) begin
                queue_cmd(bpfa_pkg::CMD_ALLOC, a,
                          hold && ($urandom_range(49) == 0 || k == n / 2));
            end else if (roll < 72) begin
                roll = $urandom_range(99);
                if (roll < 80)
                    a = base_g + (ADDR_W'($urandom_range(0, span)) << PAGE_SHIFT)
                        + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
                else if (roll < 90 && base_g != 0)
                    a = base_g - ADDR_W'($urandom_range(1, 2 * PAGE_BYTES));
                queue_cmd(bpfa_pkg::CMD_FREE, a);
            end else if (roll < 90) begin
                queue_cmd(bpfa_pkg::CMD_COUNT, a);
            end else if (roll < 94) begin
                queue_cmd(bpfa_pkg::CMD_INIT, a);
            end else begin
                queue_cmd(bpfa_pkg::CMD_FREE, a);
            end
        end
        wait_drained();
    endtask

    initial begin
        logic [ADDR_W-1:0] res;
        foreach (frame_used[k])
            frame_used[k] = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing initialised yet
        queue_cmd(bpfa_pkg::CMD_ALLOC, '0);
        queue_cmd(bpfa_pkg::CMD_FREE, '0);
        queue_cmd(bpfa_pkg::CMD_COUNT, ADDR_MAX);
        queue_cmd(bpfa_pkg::CMD_FREE, ADDR_MAX);
        wait_drained();

        // five pages above a rounded base, page zero holds the bitmap
        cfg_write(bpfa_pkg::CFG_RESERVED_END, 48'h1001);
        cfg_write(bpfa_pkg::CFG_MEMORY_END, 48'h707b);
        queue_cmd(bpfa_pkg::CMD_INIT, ADDR_MAX);
        queue_cmd(bpfa_pkg::CMD_COUNT, '0);
        repeat (5) queue_cmd(bpfa_pkg::CMD_ALLOC, '0);
        queue_cmd(bpfa_pkg::CMD_FREE, 48'h57ff);
        queue_cmd(bpfa_pkg::CMD_FREE, 48'h1fff);
        queue_cmd(bpfa_pkg::CMD_FREE, 48'h7000);
        queue_cmd(bpfa_pkg::CMD_FREE, 48'h2000);
        queue_cmd(bpfa_pkg::CMD_FREE, 48'h5000);
        queue_cmd(bpfa_pkg::CMD_COUNT, ADDR_MAX);
        repeat (3) queue_cmd(bpfa_pkg::CMD_ALLOC, ADDR_MAX);
        queue_cmd(bpfa_pkg::CMD_COUNT, '0);
        wait_drained();

        res = {16'($urandom_range(0, 16'h7fff)), 32'($urandom)};
        run_phase(res, res + 48'((12 << PAGE_SHIFT) + $urandom_range(0, 8191)), 0, 300, 1'b0);
        res = {16'($urandom_range(0, 16'h7fff)), 32'($urandom)};
        run_phase(res, res + 48'((40 << PAGE_SHIFT) + $urandom_range(0, 8191)), 62, 300, 1'b1);
        run_phase(ADDR_MAX, ADDR_MAX, 13, 250, 1'b0);
        run_phase('0, '0, 0, 60, 1'b0);
        run_phase(48'h8000_0000_0000, 48'h7fff_ffff_ffff, 62, 60, 1'b1);
        res = {16'($urandom_range(0, 16'h7fff)), 32'($urandom)};
        run_phase(res, res + 48'(PAGE_BYTES + $urandom_range(0, 4095)), 13, 150, 1'b0);
        run_phase(48'hffff_fff0_0123, ADDR_MAX, 0, 200, 1'b0);
        res = {16'($urandom_range(0, 16'h7fff)), 32'($urandom)};
        run_phase(res, res + 48'((9 << PAGE_SHIFT) + $urandom_range(0, 8191)), 62, 230, 1'b1);

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && page_results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
